// ----- rtl/sit_pkg.sv -----
// Types, widths and stage functions for the segment intersection pipeline.
// Used by segment_intersection_test_core and sit_div_step; no dependencies.
package sit_pkg;

    localparam int CW   = 24;          // coordinate width, Q16.8
    localparam int F    = 16;          // alpha fraction bits
    localparam int AW   = F + 1;       // alpha width, Q1.16
    localparam int DW   = CW + 1;      // coordinate difference
    localparam int PW   = 2 * DW;      // cross product term
    localparam int WW   = PW + 2;      // cross product and its differences
    localparam int RW   = WW + 1;      // division remainder
    localparam int PS   = 16;          // perturbation shift
    localparam int KW   = DW + 18;     // perturbation product
    localparam int SW   = KW - PS + 1; // shifted product plus partner
    localparam int DIV0 = 24;          // first divider step stage
    localparam int NS   = DIV0 + F;    // pipeline depth

    localparam logic signed [17:0] PERT_K = 18'sd65601;

    typedef struct packed {
        logic [RW-1:0] r;
        logic [WW-1:0] d;
        logic [AW-1:0] q;
        logic          done;
    } sit_quot_t;

    typedef struct packed {
        logic signed [CW-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
        logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
        logic signed [PW-1:0] m0, m1, m2, m3;
        logic signed [KW-1:0] kx, ky;
        logic signed [WW-1:0] w1, w2, u1, u2;
        logic                 z1, z2, go, hit;
        sit_quot_t            qa, qb;
    } sit_word_t;

    function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic signed [KW-1:0] kmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [DW-1:0] dv;
        dv = dif(a, b);
        return KW'(dv) * KW'(PERT_K);
    endfunction

    // floor shift of the scaled offset, add partner back, saturate
    function automatic logic signed [CW-1:0] pert(input logic signed [KW-1:0] kp,
                                                  input logic signed [CW-1:0] base);
        logic [SW-1:0] sum;
        sum = {kp[KW-1], kp[KW-1:PS]} + {{(SW-CW){base[CW-1]}}, base};
        if (sum[SW-1:CW-1] == '0 || sum[SW-1:CW-1] == '1) begin
            return sum[CW-1:0];
        end
        return sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    function automatic logic pos(input logic signed [WW-1:0] w);
        return !w[WW-1] && (w != '0);
    endfunction

    function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] w);
        return w[WW-1] ? WW'(-w) : WW'(w);
    endfunction

    function automatic sit_quot_t qinit(input sit_quot_t x, input logic hit);
        sit_quot_t o;
        logic      ge, dz;
        o  = x;
        dz = (x.d == '0);
        ge = (x.r >= {1'b0, x.d});
        o.done = !hit || dz || ge;
        o.q    = (hit && !dz && ge) ? {1'b1, {F{1'b0}}} : '0;
        return o;
    endfunction

    // geometry stage k, fed by the word held in stage k-1
    function automatic sit_word_t geo_step(input int unsigned k, input sit_word_t s);
        sit_word_t r;
        r = s;
        unique case (k)
            1: begin
                r.cx = dif(s.q2x, s.q1x); r.cy = dif(s.q2y, s.q1y);
                r.ax = dif(s.p1x, s.q1x); r.ay = dif(s.p1y, s.q1y);
                r.bx = dif(s.p2x, s.q1x); r.by = dif(s.p2y, s.q1y);
            end
            2: begin
                r.m0 = s.ay * s.cx; r.m1 = s.ax * s.cy;
                r.m2 = s.by * s.cx; r.m3 = s.bx * s.cy;
            end
            3: begin
                r.w1 = WW'(s.m0) - WW'(s.m1); r.w2 = WW'(s.m2) - WW'(s.m3);
                r.z1 = (s.m0 == s.m1);       r.z2 = (s.m2 == s.m3);
            end
            4: begin
                r.kx = kmul(s.p1x, s.p2x); r.ky = kmul(s.p1y, s.p2y);
            end
            5: begin
                if (s.z1) begin
                    r.p1x = pert(s.kx, s.p2x); r.p1y = pert(s.ky, s.p2y);
                end
            end
            6: begin
                r.ax = dif(s.p1x, s.q1x); r.ay = dif(s.p1y, s.q1y);
                r.kx = kmul(s.p2x, s.p1x); r.ky = kmul(s.p2y, s.p1y);
            end
            7: begin
                r.m0 = s.ay * s.cx; r.m1 = s.ax * s.cy;
                if (s.z2) begin
                    r.p2x = pert(s.kx, s.p1x); r.p2y = pert(s.ky, s.p1y);
                end
            end
            8: begin
                if (s.z1) begin
                    r.w1 = WW'(s.m0) - WW'(s.m1);
                end
                r.bx = dif(s.p2x, s.q1x); r.by = dif(s.p2y, s.q1y);
            end
            9: begin
                r.m2 = s.by * s.cx; r.m3 = s.bx * s.cy;
            end
            10: begin
                if (s.z2) begin
                    r.w2 = WW'(s.m2) - WW'(s.m3);
                end
            end
            11: begin
                r.go = (s.w1[WW-1] && pos(s.w2)) || (pos(s.w1) && s.w2[WW-1]);
                r.cx = dif(s.p2x, s.p1x); r.cy = dif(s.p2y, s.p1y);
                r.ax = dif(s.q1x, s.p1x); r.ay = dif(s.q1y, s.p1y);
                r.bx = dif(s.q2x, s.p1x); r.by = dif(s.q2y, s.p1y);
            end
            12: begin
                r.m0 = s.ay * s.cx; r.m1 = s.ax * s.cy;
                r.m2 = s.by * s.cx; r.m3 = s.bx * s.cy;
            end
            13: begin
                r.u1 = WW'(s.m0) - WW'(s.m1); r.u2 = WW'(s.m2) - WW'(s.m3);
                r.z1 = s.go && (s.m0 == s.m1);
                r.z2 = s.go && (s.m2 == s.m3);
            end
            14: begin
                r.kx = kmul(s.q1x, s.q2x); r.ky = kmul(s.q1y, s.q2y);
            end
            15: begin
                if (s.z1) begin
                    r.q1x = pert(s.kx, s.q2x); r.q1y = pert(s.ky, s.q2y);
                end
            end
            16: begin
                r.ax = dif(s.q1x, s.p1x); r.ay = dif(s.q1y, s.p1y);
                r.kx = kmul(s.q2x, s.q1x); r.ky = kmul(s.q2y, s.q1y);
            end
            17: begin
                r.m0 = s.ay * s.cx; r.m1 = s.ax * s.cy;
                if (s.z2) begin
                    r.q2x = pert(s.kx, s.q1x); r.q2y = pert(s.ky, s.q1y);
                end
            end
            18: begin
                if (s.z1) begin
                    r.u1 = WW'(s.m0) - WW'(s.m1);
                end
                r.bx = dif(s.q2x, s.p1x); r.by = dif(s.q2y, s.p1y);
            end
            19: begin
                r.m2 = s.by * s.cx; r.m3 = s.bx * s.cy;
            end
            20: begin
                if (s.z2) begin
                    r.u2 = WW'(s.m2) - WW'(s.m3);
                end
            end
            21: begin
                r.hit = s.go && !((pos(s.u1) && pos(s.u2)) ||
                                  (s.u1[WW-1] && s.u2[WW-1]));
                r.w2 = s.w1 - s.w2;
                r.u2 = s.u1 - s.u2;
            end
            22: begin
                r.qa.r = RW'(mag(s.w1)); r.qa.d = mag(s.w2);
                r.qb.r = RW'(mag(s.u1)); r.qb.d = mag(s.u2);
            end
            23: begin
                r.qa = qinit(s.qa, s.hit);
                r.qb = qinit(s.qb, s.hit);
            end
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/sit_div_step.sv -----
// One restoring division step: one quotient bit per stage.
// Depends on sit_pkg (sit_quot_t).
module sit_div_step (
    input  sit_pkg::sit_quot_t q_in,
    output sit_pkg::sit_quot_t q_out
);

    logic [sit_pkg::RW-1:0] r2;
    logic                   ge;

    assign r2 = {q_in.r[sit_pkg::RW-2:0], 1'b0};
    assign ge = (r2 >= {1'b0, q_in.d});

    always_comb begin
        q_out = q_in;
        if (!q_in.done) begin
            q_out.r = ge ? (r2 - {1'b0, q_in.d}) : r2;
            q_out.q = {q_in.q[sit_pkg::AW-2:0], ge};
        end
    end

endmodule

// ----- rtl/segment_intersection_test_core.sv -----
// Segment crossing test with endpoint perturbation, fully pipelined.
// Depends on sit_pkg and sit_div_step.
//
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | two segments, eight Q16.8 coordinates
//  m_      | out | m_valid / m_ready  | crosses flag, two Q1.16 alphas, endpoints
//
// 40 register stages: the accepted word passes through each in turn to the last
// stage; one word per cycle sustained while m_ready stays high.
// Stage 0 captures the input, stages 1 to 23 do the geometry (cross products,
// perturbation, recomputation, quotient set-up), then 16 stages each resolve
// one quotient bit of both alphas.
// aresetn (synchronous, active low) clears the stage valid bits only.
// Each stage holds its word while its successor is full and stalled, so
// s_ready falls only when every stage holds a word and m_ready is low.
module segment_intersection_test_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [sit_pkg::CW-1:0]   s_p_start_x,
    input  logic signed [sit_pkg::CW-1:0]   s_p_start_y,
    input  logic signed [sit_pkg::CW-1:0]   s_p_end_x,
    input  logic signed [sit_pkg::CW-1:0]   s_p_end_y,
    input  logic signed [sit_pkg::CW-1:0]   s_q_start_x,
    input  logic signed [sit_pkg::CW-1:0]   s_q_start_y,
    input  logic signed [sit_pkg::CW-1:0]   s_q_end_x,
    input  logic signed [sit_pkg::CW-1:0]   s_q_end_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_crosses,
    output logic [sit_pkg::AW-1:0]          m_alpha_along_p,
    output logic [sit_pkg::AW-1:0]          m_alpha_along_q,
    output logic signed [sit_pkg::CW-1:0]   m_out_p_start_x,
    output logic signed [sit_pkg::CW-1:0]   m_out_p_start_y,
    output logic signed [sit_pkg::CW-1:0]   m_out_p_end_x,
    output logic signed [sit_pkg::CW-1:0]   m_out_p_end_y,
    output logic signed [sit_pkg::CW-1:0]   m_out_q_start_x,
    output logic signed [sit_pkg::CW-1:0]   m_out_q_start_y,
    output logic signed [sit_pkg::CW-1:0]   m_out_q_end_x,
    output logic signed [sit_pkg::CW-1:0]   m_out_q_end_y
);

    sit_pkg::sit_word_t pipe_reg [sit_pkg::NS];
    sit_pkg::sit_word_t pipe_next[sit_pkg::NS];
    logic               vld_reg  [sit_pkg::NS];
    logic               en       [sit_pkg::NS];

    sit_pkg::sit_quot_t qa_step[sit_pkg::DIV0:sit_pkg::NS-1];
    sit_pkg::sit_quot_t qb_step[sit_pkg::DIV0:sit_pkg::NS-1];

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        en[sit_pkg::NS-1] = !vld_reg[sit_pkg::NS-1] || m_ready;
        for (int k = sit_pkg::NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    // divider steps, one pair per stage
    for (genvar g = sit_pkg::DIV0; g < sit_pkg::NS; g++) begin : g_div
        sit_div_step u_step_a (.q_in(pipe_reg[g-1].qa), .q_out(qa_step[g]));
        sit_div_step u_step_b (.q_in(pipe_reg[g-1].qb), .q_out(qb_step[g]));
    end

    always_comb begin
        pipe_next[0]     = '0;
        pipe_next[0].p1x = s_p_start_x;
        pipe_next[0].p1y = s_p_start_y;
        pipe_next[0].p2x = s_p_end_x;
        pipe_next[0].p2y = s_p_end_y;
        pipe_next[0].q1x = s_q_start_x;
        pipe_next[0].q1y = s_q_start_y;
        pipe_next[0].q2x = s_q_end_x;
        pipe_next[0].q2y = s_q_end_y;
        for (int k = 1; k < sit_pkg::DIV0; k++) begin
            pipe_next[k] = sit_pkg::geo_step(k, pipe_reg[k-1]);
        end
        for (int k = sit_pkg::DIV0; k < sit_pkg::NS; k++) begin
            pipe_next[k]    = pipe_reg[k-1];
            pipe_next[k].qa = qa_step[k];
            pipe_next[k].qb = qb_step[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < sit_pkg::NS; k++) begin
            if (en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < sit_pkg::NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < sit_pkg::NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // result word straight from the last stage
    assign m_valid         = vld_reg[sit_pkg::NS-1];
    assign m_crosses       = pipe_reg[sit_pkg::NS-1].hit;
    assign m_alpha_along_p = pipe_reg[sit_pkg::NS-1].qa.q;
    assign m_alpha_along_q = pipe_reg[sit_pkg::NS-1].qb.q;
    assign m_out_p_start_x = pipe_reg[sit_pkg::NS-1].p1x;
    assign m_out_p_start_y = pipe_reg[sit_pkg::NS-1].p1y;
    assign m_out_p_end_x   = pipe_reg[sit_pkg::NS-1].p2x;
    assign m_out_p_end_y   = pipe_reg[sit_pkg::NS-1].p2y;
    assign m_out_q_start_x = pipe_reg[sit_pkg::NS-1].q1x;
    assign m_out_q_start_y = pipe_reg[sit_pkg::NS-1].q1y;
    assign m_out_q_end_x   = pipe_reg[sit_pkg::NS-1].q2x;
    assign m_out_q_end_y   = pipe_reg[sit_pkg::NS-1].q2y;

`ifndef SYNTHESIS
    a_no_hit_zero_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_crosses) |-> (m_alpha_along_p == '0 && m_alpha_along_q == '0))
        else $error("alpha non-zero without a crossing");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_alpha_along_p <= {1'b1, {sit_pkg::F{1'b0}}} &&
                     m_alpha_along_q <= {1'b1, {sit_pkg::F{1'b0}}}))
        else $error("alpha above one");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");
`endif

endmodule

// ----- tb/segment_intersection_test_core_tb.sv -----
// Self-checking bench for segment_intersection_test_core: segment pairs in,
// crossing flag, alphas and perturbed endpoints out, checked against a predictor.
// Depends on sit_pkg and the core RTL.
module segment_intersection_test_core_tb;

    localparam int CW          = sit_pkg::CW;
    localparam int AW          = sit_pkg::AW;
    localparam int F           = sit_pkg::F;
    localparam int PS          = sit_pkg::PS;
    localparam int RUN_ITEMS   = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 80;    // comfortably over the pipeline latency
    localparam int HOLD_LEN    = 300;   // long receiver hold-off, in cycles
    localparam longint K_PERT  = 65601;

    // coordinate order: p start x/y, p end x/y, q start x/y, q end x/y
    typedef struct {
        logic signed [CW-1:0] c[8];
    } seg_pair_t;

    typedef struct {
        logic                 crosses;
        logic [AW-1:0]        ap;
        logic [AW-1:0]        aq;
        logic signed [CW-1:0] c[8];
    } crossing_t;

    // ---------------------------------------------------------------
    // Crossing predictor and queue of pending crossing results
    // ---------------------------------------------------------------
    class crossing_sb;
        crossing_t pending[$];
        int        mismatches;
        int        results;
        int        hits;
        int        nudged;

        static function longint clamp_coord(longint v);
            longint hi, lo;
            hi = (longint'(1) <<< (CW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // push an endpoint off the line, away from its partner, by ~1.001
        static function longint nudge(longint self_c, longint partner);
            longint m;
            m = (self_c - partner) * K_PERT;
            return clamp_coord((m >>> PS) + partner);
        endfunction

        static function longint side(longint vx, longint vy, longint dx, longint dy);
            return vy * dx - vx * dy;
        endfunction

        static function logic [AW-1:0] alpha(longint n, longint d);
            logic [127:0] un, ud, qv;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            if (ud == 0) return '0;
            if (un >= ud) return AW'(1) << F;
            qv = (un << F) / ud;
            return qv[AW-1:0];
        endfunction

        function void note(seg_pair_t s);
            crossing_t r;
            longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, dx, dy;
            longint wp1, wp2, wq1, wq2;
            p1x = s.c[0]; p1y = s.c[1]; p2x = s.c[2]; p2y = s.c[3];
            q1x = s.c[4]; q1y = s.c[5]; q2x = s.c[6]; q2y = s.c[7];
            r.crosses = 1'b0;
            r.ap = '0;
            r.aq = '0;
            dx = q2x - q1x; dy = q2y - q1y;
            wp1 = side(p1x - q1x, p1y - q1y, dx, dy);
            wp2 = side(p2x - q1x, p2y - q1y, dx, dy);
            if (wp1 == 0) begin
                p1x = nudge(p1x, p2x); p1y = nudge(p1y, p2y);
                wp1 = side(p1x - q1x, p1y - q1y, dx, dy);
                nudged++;
            end
            if (wp2 == 0) begin
                p2x = nudge(p2x, p1x); p2y = nudge(p2y, p1y);
                wp2 = side(p2x - q1x, p2y - q1y, dx, dy);
            end
            if ((wp1 < 0 && wp2 > 0) || (wp1 > 0 && wp2 < 0)) begin
                dx = p2x - p1x; dy = p2y - p1y;
                wq1 = side(q1x - p1x, q1y - p1y, dx, dy);
                wq2 = side(q2x - p1x, q2y - p1y, dx, dy);
                if (wq1 == 0) begin
                    q1x = nudge(q1x, q2x); q1y = nudge(q1y, q2y);
                    wq1 = side(q1x - p1x, q1y - p1y, dx, dy);
                end
                if (wq2 == 0) begin
                    q2x = nudge(q2x, q1x); q2y = nudge(q2y, q1y);
                    wq2 = side(q2x - p1x, q2y - p1y, dx, dy);
                end
                if (!((wq1 > 0 && wq2 > 0) || (wq1 < 0 && wq2 < 0))) begin
                    r.crosses = 1'b1;
                    r.ap = alpha(wp1, wp1 - wp2);
                    r.aq = alpha(wq1, wq1 - wq2);
                    hits++;
                end
            end
            r.c[0] = p1x[CW-1:0]; r.c[1] = p1y[CW-1:0];
            r.c[2] = p2x[CW-1:0]; r.c[3] = p2y[CW-1:0];
            r.c[4] = q1x[CW-1:0]; r.c[5] = q1y[CW-1:0];
            r.c[6] = q2x[CW-1:0]; r.c[7] = q2y[CW-1:0];
            pending = {pending, r};
        endfunction

        function void flag(string what, longint exp_v, longint got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results, what, exp_v, got_v);
        endfunction

        function void check(crossing_t got);
            crossing_t e;
            string names[8];
            names = '{"p_start_x", "p_start_y", "p_end_x", "p_end_y",
                      "q_start_x", "q_start_y", "q_end_x", "q_end_y"};
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result %0d arrived unexpected", results);
                results++;
                return;
            end
            e = pending.pop_front();
            if (got.crosses !== e.crosses) flag("crosses", e.crosses, got.crosses);
            if (got.ap !== e.ap) flag("alpha_along_p", e.ap, got.ap);
            if (got.aq !== e.aq) flag("alpha_along_q", e.aq, got.aq);
            for (int i = 0; i < 8; i++)
                if (got.c[i] !== e.c[i]) flag(names[i], e.c[i], got.c[i]);
            results++;
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [CW-1:0] s_c[8];
    logic m_crosses;
    logic [AW-1:0] m_ap, m_aq;
    logic signed [CW-1:0] m_c[8];

    crossing_sb sb;
    int     sent;
    int     cycles;
    logic   holding;
    int     rx_wait;
    logic   rx_burst;

    segment_intersection_test_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p_start_x(s_c[0]), .s_p_start_y(s_c[1]),
        .s_p_end_x(s_c[2]), .s_p_end_y(s_c[3]),
        .s_q_start_x(s_c[4]), .s_q_start_y(s_c[5]),
        .s_q_end_x(s_c[6]), .s_q_end_y(s_c[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_crosses(m_crosses),
        .m_alpha_along_p(m_ap), .m_alpha_along_q(m_aq),
        .m_out_p_start_x(m_c[0]), .m_out_p_start_y(m_c[1]),
        .m_out_p_end_x(m_c[2]), .m_out_p_end_y(m_c[3]),
        .m_out_q_start_x(m_c[4]), .m_out_q_start_y(m_c[5]),
        .m_out_q_end_x(m_c[6]), .m_out_q_end_y(m_c[7])
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, sb.pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: check each accepted word, then draw the stall before the next.
    // Every so often a burst stretch with no stalls at all.
    always @(posedge aclk) begin
        crossing_t got;
        logic nxt;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
            rx_burst <= 1'b0;
        end else begin
            nxt = 1'b1;
            if (m_valid && m_ready) begin
                got.crosses = m_crosses;
                got.ap = m_ap;
                got.aq = m_aq;
                for (int i = 0; i < 8; i++) got.c[i] = m_c[i];
                sb.check(got);
                if ($urandom_range(0, 63) == 0) rx_burst <= ~rx_burst;
                rx_wait <= rx_burst ? 0 : $urandom_range(0, 8);
                nxt = rx_burst || ($urandom_range(0, 8) == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                nxt = 1'b0;
            end
            if (holding) nxt = 1'b0;
            m_ready <= nxt;
        end
    end

    // Long hold-off on the result side so the pipeline fills and stalls input.
    initial begin
        holding = 1'b0;
        wait (sent >= 400);
        @(posedge aclk);
        holding <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        holding <= 1'b0;
    end

    // drive one word, honouring the gap; valid stays high across back-to-back words
    task automatic send_pair(seg_pair_t s, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 8; i++) s_c[i] <= s.c[i];
        do @(posedge aclk); while (!s_ready);
        sb.note(s);
        sent++;
    endtask

    function automatic seg_pair_t pair_of(longint a, longint b, longint c, longint d,
                                          longint e, longint f, longint g, longint h);
        seg_pair_t s;
        s.c[0] = a[CW-1:0]; s.c[1] = b[CW-1:0]; s.c[2] = c[CW-1:0]; s.c[3] = d[CW-1:0];
        s.c[4] = e[CW-1:0]; s.c[5] = f[CW-1:0]; s.c[6] = g[CW-1:0]; s.c[7] = h[CW-1:0];
        return s;
    endfunction

    function automatic logic signed [CW-1:0] rnd_coord(int span);
        if (span == 0) return CW'($urandom);
        return CW'($urandom_range(0, 2 * span) - span);
    endfunction

    // Mostly small coordinates (many touches, collinear cases, crossings),
    // some full range, some with an endpoint placed exactly on the other line.
    function automatic seg_pair_t rnd_pair();
        seg_pair_t s;
        int span, kind, k;
        kind = $urandom_range(0, 9);
        span = (kind < 3) ? 0 : (kind < 6) ? 8 : (kind < 8) ? 2000 : 40;
        for (int i = 0; i < 8; i++) s.c[i] = rnd_coord(span);
        if (kind >= 8) begin
            // endpoint on the line: q start plus k times the q direction
            k = $urandom_range(0, 3) - 1;
            for (int a = 0; a < 2; a++)
                s.c[($urandom_range(0, 1) ? 2 : 0) + a] =
                    CW'(s.c[4 + a] + k * (s.c[6 + a] - s.c[4 + a]));
            if ($urandom_range(0, 1))
                for (int a = 0; a < 2; a++)
                    s.c[4 + a] = s.c[$urandom_range(0, 1) * 2 + a];
        end
        return s;
    endfunction

    localparam longint MX = 8388607;
    localparam longint MN = -8388608;

    initial begin
        seg_pair_t dir[$];
        int gap;
        logic burst;
        sb = new();
        sent = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        for (int i = 0; i < 8; i++) s_c[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words
        dir = {dir, pair_of(0, 0, 0, 0, 0, 0, 0, 0)};                 // all degenerate
        dir = {dir, pair_of(-10, 0, 10, 0, 0, -10, 0, 10)};           // plain cross
        dir = {dir, pair_of(-10, 0, 10, 0, 20, -10, 20, 10)};         // miss
        dir = {dir, pair_of(0, 0, 10, 10, 0, 5, 10, 15)};             // parallel
        dir = {dir, pair_of(0, 0, 10, 10, 20, 20, 30, 30)};           // collinear
        dir = {dir, pair_of(0, 0, 10, 0, 0, -5, 0, 5)};               // p start on q
        dir = {dir, pair_of(-10, 0, 0, 0, 0, -5, 0, 5)};              // p end on q
        dir = {dir, pair_of(-10, 3, 10, 3, 0, 3, 0, 10)};             // q start touches
        dir = {dir, pair_of(-10, 3, 10, 3, 0, -10, 0, 3)};            // q end touches
        dir = {dir, pair_of(-10, 3, 10, 3, 0, 3, 0, 3)};              // q a point on p
        dir = {dir, pair_of(MX, 0, MN, 100, -5, 0, 5, 0)};            // nudge saturates high
        dir = {dir, pair_of(MN, 0, MX, -100, -5, 0, 5, 0)};           // nudge saturates low
        dir = {dir, pair_of(MN, MN, MX, MX, MN, MX, MX, MN)};         // extreme cross
        dir = {dir, pair_of(MX, MX, MN, MN, MX, MN, MN, MX)};
        dir = {dir, pair_of(MN, MN, MN, MN, MX, MX, MX, MX)};
        dir = {dir, pair_of(MN, 0, MX, 1, 0, MN, 1, MX)};
        dir = {dir, pair_of(-1, -1, 1, 1, -1, 1, 1, -1)};             // tiny cross
        dir = {dir, pair_of(-3, 0, 1, 0, 0, -1, 0, 7)};               // uneven alphas
        dir = {dir, pair_of(0, 0, 5, 5, 0, 0, 5, 5)};                 // identical segments
        dir = {dir, pair_of(0, 0, 10, 0, 10, 0, 10, 10)};             // shared endpoint
        foreach (dir[i]) send_pair(dir[i], $urandom_range(0, 2));

        // random words; gaps drawn per word, with burst stretches
        burst = 1'b0;
        for (int n = 0; n < RUN_ITEMS; n++) begin
            if ($urandom_range(0, 49) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 8);
            send_pair(rnd_pair(), gap);
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("%0d segment pairs sent, %0d results checked: %0d crossings, %0d nudged",
                 sent, sb.results, sb.hits, sb.nudged);
        $display("mismatches: %0d, leftover expectations: %0d",
                 sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
